// ===== src/atr_pkg.sv =====
// atr_pkg: shared constants, types and helper functions for the atlas texcoord remap
// used by atr_prep, atr_mul, atr_div and atlas_texcoord_remap; depends on nothing

package atr_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = 13;
	localparam int POS_W      = 12;
	localparam int COORD_W    = 32;
	localparam int PROD_W     = COORD_W + DIM_W + 1;
	localparam int MAG_W      = 44;
	localparam int QUO_W      = 32;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = QUO_W / DIV_BITS;
	// prep, multiply, add, magnitude, divider stages, saturate/output
	localparam int LAT        = 4 + DIV_STAGES + 1;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SHEET_WIDTH  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SHEET_HEIGHT = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SHEET_X      = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_SHEET_Y      = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_FLAGS  = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_PICMIP_PAIR  = 3'd7;

	localparam logic [QUO_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [QUO_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef logic [DIM_W-1:0] dim_t;

	typedef struct packed {
		dim_t        image_width;
		dim_t        image_height;
		logic [1:0]  image_flags;
		logic [15:0] picmip_pair;
	} atr_cfg_t;

	function automatic dim_t clamp_dim(dim_t d);
		return (d > dim_t'(MAX_DIM)) ? dim_t'(MAX_DIM) : d;
	endfunction

	// divisor for one axis: clamped, zero taken as one
	function automatic dim_t sheet_div(dim_t d);
		dim_t c;
		c = clamp_dim(d);
		return (c == '0) ? dim_t'(1) : c;
	endfunction

	// reduction level 0..3 from flags and the signed level bytes
	function automatic logic [1:0] level(atr_cfg_t c);
		logic [7:0] b;
		b = c.image_flags[1] ? c.picmip_pair[15:8] : c.picmip_pair[7:0];
		if (!c.image_flags[0])
			return 2'd0;
		if (b[7])
			return 2'd0;
		if (b[6:0] > 7'd3)
			return 2'd3;
		return b[1:0];
	endfunction

endpackage

// ===== src/atlas_texcoord_remap.sv =====
// atlas_texcoord_remap: top level, configuration registers, valid chain and axis datapaths
// depends on atr_pkg, atr_prep, atr_mul, atr_div
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata = tex_u, tex_v; s_tlast = last_vertex
// m_        out  m_tvalid/m_tready  m_tdata = sheet_u, sheet_v; m_tlast = last_out
// cfg_      in   cfg_we             cfg_addr = register index, cfg_wdata = value
//
// one beat per cycle while the output beat is not held
// the divider has eight stages of four quotient bits each
// arst_n clears the configuration to its reset values and empties the pipeline
// a stalled output beat freezes all stages; s_tready is low only while that beat waits
// and m_tready is low

module atlas_texcoord_remap (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [63:0]                        s_tdata,   // tex_u [31:0], tex_v [63:32]
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [63:0]                        m_tdata,   // sheet_u [31:0], sheet_v [63:32]
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [atr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [atr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int LAT = atr_pkg::LAT;

	atr_pkg::dim_t               image_width_q;
	atr_pkg::dim_t               image_height_q;
	atr_pkg::dim_t               sheet_width_q;
	atr_pkg::dim_t               sheet_height_q;
	logic [atr_pkg::POS_W-1:0]   sheet_x_q;
	logic [atr_pkg::POS_W-1:0]   sheet_y_q;
	logic [1:0]                  image_flags_q;
	logic [15:0]                 picmip_pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= atr_pkg::dim_t'(1);
			image_height_q <= atr_pkg::dim_t'(1);
			sheet_width_q  <= atr_pkg::dim_t'(1);
			sheet_height_q <= atr_pkg::dim_t'(1);
			sheet_x_q      <= '0;
			sheet_y_q      <= '0;
			image_flags_q  <= '0;
			picmip_pair_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				atr_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[atr_pkg::DIM_W-1:0];
				atr_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[atr_pkg::DIM_W-1:0];
				atr_pkg::REG_SHEET_WIDTH:  sheet_width_q  <= cfg_wdata[atr_pkg::DIM_W-1:0];
				atr_pkg::REG_SHEET_HEIGHT: sheet_height_q <= cfg_wdata[atr_pkg::DIM_W-1:0];
				atr_pkg::REG_SHEET_X:      sheet_x_q      <= cfg_wdata[atr_pkg::POS_W-1:0];
				atr_pkg::REG_SHEET_Y:      sheet_y_q      <= cfg_wdata[atr_pkg::POS_W-1:0];
				atr_pkg::REG_IMAGE_FLAGS:  image_flags_q  <= cfg_wdata[1:0];
				atr_pkg::REG_PICMIP_PAIR:  picmip_pair_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	atr_pkg::atr_cfg_t cfg;
	atr_pkg::dim_t     div_u;
	atr_pkg::dim_t     div_v;

	always_comb begin
		cfg.image_width  = image_width_q;
		cfg.image_height = image_height_q;
		cfg.image_flags  = image_flags_q;
		cfg.picmip_pair  = picmip_pair_q;
		div_u = atr_pkg::sheet_div(sheet_width_q);
		div_v = atr_pkg::sheet_div(sheet_height_q);
	end

	// whole pipeline moves unless the output beat is held
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [LAT-1:0] vld_s;
	logic [LAT-1:0] last_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
	end

	always_ff @(posedge clk) begin
		if (en)
			last_s <= {last_s[LAT-2:0], s_tlast};
	end

	logic signed [atr_pkg::COORD_W-1:0] u_src_s1;
	logic signed [atr_pkg::COORD_W-1:0] v_src_s1;
	atr_pkg::dim_t                      u_dim_s1;
	atr_pkg::dim_t                      v_dim_s1;

	atr_prep u_prep (
		.clk      (clk),
		.en       (en),
		.cfg      (cfg),
		.tex_u    (s_tdata[31:0]),
		.tex_v    (s_tdata[63:32]),
		.u_src_s1 (u_src_s1),
		.v_src_s1 (v_src_s1),
		.u_dim_s1 (u_dim_s1),
		.v_dim_s1 (v_dim_s1)
	);

	logic                        u_neg_s4;
	logic                        v_neg_s4;
	logic [atr_pkg::MAG_W-1:0]   u_mag_s4;
	logic [atr_pkg::MAG_W-1:0]   v_mag_s4;

	atr_mul u_mul_u (
		.clk    (clk),
		.en     (en),
		.src    (u_src_s1),
		.dim    (u_dim_s1),
		.pos    (sheet_x_q),
		.neg_s4 (u_neg_s4),
		.mag_s4 (u_mag_s4)
	);

	atr_mul u_mul_v (
		.clk    (clk),
		.en     (en),
		.src    (v_src_s1),
		.dim    (v_dim_s1),
		.pos    (sheet_y_q),
		.neg_s4 (v_neg_s4),
		.mag_s4 (v_mag_s4)
	);

	logic [atr_pkg::QUO_W-1:0] u_res_s13;
	logic [atr_pkg::QUO_W-1:0] v_res_s13;

	atr_div u_div_u (
		.clk     (clk),
		.en      (en),
		.neg     (u_neg_s4),
		.mag     (u_mag_s4),
		.d       (div_u),
		.res_s13 (u_res_s13)
	);

	atr_div u_div_v (
		.clk     (clk),
		.en      (en),
		.neg     (v_neg_s4),
		.mag     (v_mag_s4),
		.d       (div_v),
		.res_s13 (v_res_s13)
	);

	assign m_tvalid = vld_s[LAT-1];
	assign m_tlast  = last_s[LAT-1];
	assign m_tdata  = {v_res_s13, u_res_s13};

	// an item enters the chain only through an accepted input beat
	a_entry_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s[0]) |-> $past(s_tvalid && s_tready))
		else $error("pipeline entry without input beat");

	// a held output beat freezes every stage
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(vld_s))
		else $error("pipeline moved during output stall");

	// with every stage full, an input beat is taken only together with an output beat
	a_full_needs_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && ($countones(vld_s) == LAT) |-> m_tready)
		else $error("input beat taken into a full pipeline");

endmodule

// ===== src/atr_prep.sv =====
// atr_prep: stage 1, level select, extent shift and axis swap
// depends on atr_pkg

module atr_prep (
	input  logic                              clk,
	input  logic                              en,
	input  atr_pkg::atr_cfg_t                 cfg,
	input  logic signed [atr_pkg::COORD_W-1:0] tex_u,
	input  logic signed [atr_pkg::COORD_W-1:0] tex_v,
	output logic signed [atr_pkg::COORD_W-1:0] u_src_s1,
	output logic signed [atr_pkg::COORD_W-1:0] v_src_s1,
	output atr_pkg::dim_t                     u_dim_s1,
	output atr_pkg::dim_t                     v_dim_s1
);

	logic [1:0]     lvl;
	atr_pkg::dim_t  w_dim;
	atr_pkg::dim_t  h_dim;
	logic           swap;

	always_comb begin
		lvl   = atr_pkg::level(cfg);
		w_dim = atr_pkg::clamp_dim(cfg.image_width) >> lvl;
		h_dim = atr_pkg::clamp_dim(cfg.image_height) >> lvl;
		swap  = cfg.image_width < cfg.image_height;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (swap) begin
				u_src_s1 <= tex_v;
				u_dim_s1 <= h_dim;
				v_src_s1 <= tex_u;
				v_dim_s1 <= w_dim;
			end else begin
				u_src_s1 <= tex_u;
				u_dim_s1 <= w_dim;
				v_src_s1 <= tex_v;
				v_dim_s1 <= h_dim;
			end
		end
	end

endmodule

// ===== src/atr_mul.sv =====
// atr_mul: stages 2 to 4 for one axis, scale product, sheet offset, sign and magnitude
// depends on atr_pkg

module atr_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [atr_pkg::COORD_W-1:0] src,
	input  atr_pkg::dim_t                      dim,
	input  logic [atr_pkg::POS_W-1:0]          pos,
	output logic                               neg_s4,
	output logic [atr_pkg::MAG_W-1:0]          mag_s4
);

	logic signed [atr_pkg::PROD_W-1:0] prod_s2;
	logic signed [atr_pkg::PROD_W-1:0] sum_s3;
	logic signed [atr_pkg::PROD_W-1:0] offs;
	logic signed [atr_pkg::PROD_W-1:0] abs_c;

	// offset in texels moved up to q16.16
	assign offs  = $signed({{(atr_pkg::PROD_W - atr_pkg::POS_W - 16){1'b0}}, pos, 16'd0});
	assign abs_c = sum_s3[atr_pkg::PROD_W-1] ? -sum_s3 : sum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= src * $signed({1'b0, dim});
			sum_s3  <= prod_s2 + offs;
			neg_s4  <= sum_s3[atr_pkg::PROD_W-1];
			mag_s4  <= abs_c[atr_pkg::MAG_W-1:0];
		end
	end

endmodule

// ===== src/atr_div.sv =====
// atr_div: stages 5 to 13 for one axis, pipelined restoring divide by the sheet extent,
// four quotient bits per stage, then sign and saturation; depends on atr_pkg

module atr_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          neg,
	input  logic [atr_pkg::MAG_W-1:0]     mag,
	input  atr_pkg::dim_t                 d,
	output logic [atr_pkg::QUO_W-1:0]     res_s13
);

	localparam int NS = atr_pkg::DIV_STAGES;
	localparam int QW = atr_pkg::QUO_W;
	localparam int HW = atr_pkg::MAG_W - QW;

	// one entry per divider stage, stage 5 onward
	atr_pkg::dim_t   rem_s [NS];
	logic [QW-1:0]   num_s [NS];
	logic [QW-1:0]   quo_s [NS];
	logic            neg_s [NS];
	logic            ovf_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		atr_pkg::dim_t r_in;
		logic [QW-1:0] n_in;
		logic [QW-1:0] q_in;
		logic          ng_in;
		logic          ov_in;
		atr_pkg::dim_t r_nx;
		logic [QW-1:0] n_nx;
		logic [QW-1:0] q_nx;

		if (k == 0) begin : g_first
			// quotient needs more than 32 bits once the high part reaches the divisor
			assign r_in  = atr_pkg::dim_t'(mag[atr_pkg::MAG_W-1:QW]);
			assign n_in  = mag[QW-1:0];
			assign q_in  = '0;
			assign ng_in = neg;
			assign ov_in = {{(atr_pkg::DIM_W - HW){1'b0}}, mag[atr_pkg::MAG_W-1:QW]} >= d;
		end else begin : g_next
			assign r_in  = rem_s[k-1];
			assign n_in  = num_s[k-1];
			assign q_in  = quo_s[k-1];
			assign ng_in = neg_s[k-1];
			assign ov_in = ovf_s[k-1];
		end

		always_comb begin : p_steps
			logic [atr_pkg::DIM_W:0] t;
			r_nx = r_in;
			n_nx = n_in;
			q_nx = q_in;
			for (int j = 0; j < atr_pkg::DIV_BITS; j++) begin
				t    = {r_nx, n_nx[QW-1]};
				n_nx = {n_nx[QW-2:0], 1'b0};
				if (t >= {1'b0, d}) begin
					t    = t - {1'b0, d};
					q_nx = {q_nx[QW-2:0], 1'b1};
				end else begin
					q_nx = {q_nx[QW-2:0], 1'b0};
				end
				r_nx = t[atr_pkg::DIM_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nx;
				num_s[k] <= n_nx;
				quo_s[k] <= q_nx;
				neg_s[k] <= ng_in;
				ovf_s[k] <= ov_in;
			end
		end
	end

	logic [QW-1:0] q_fin;
	logic          big;
	logic [QW-1:0] res_c;

	always_comb begin
		q_fin = quo_s[NS-1];
		big   = ovf_s[NS-1] | q_fin[QW-1];
		if (neg_s[NS-1])
			res_c = big ? atr_pkg::SAT_MIN : -q_fin;
		else
			res_c = big ? atr_pkg::SAT_MAX : q_fin;
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s13 <= res_c;
	end

endmodule

// ===== tb/sv/atr_remap_check.sv =====
// atr_remap_check: watches the input, output and register-write ports of atlas_texcoord_remap
// keeps its own copy of the registers, predicts each remapped coordinate pair and compares
// depends on atr_pkg for register indexes and widths

module atr_remap_check
	import atr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [63:0]           s_tdata,   // tex_u [31:0], tex_v [63:32]
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [63:0]           m_tdata,   // sheet_u [31:0], sheet_v [63:32]
	input  logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    errors,
	output int                    pending
);

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] u;
		logic [31:0] v;
		logic        last;
	} sheet_coord_t;

	logic [12:0] img_w, img_h, sht_w, sht_h;
	logic [11:0] pos_x, pos_y;
	logic [1:0]  flags;
	logic [15:0] level_pair;

	sheet_coord_t pending_coords [$];
	sheet_coord_t want, got;

	initial errors = 0;

	function automatic logic [1:0] picmip_level();
		logic signed [7:0] pick;
		if (!flags[0])
			return 2'd0;
		pick = flags[1] ? level_pair[15:8] : level_pair[7:0];
		if (pick < 0)
			return 2'd0;
		if (pick > 3)
			return 2'd3;
		return pick[1:0];
	endfunction

	// (src * (dim >> lvl) + pos * 65536) / sheet_dim, truncated and saturated
	function automatic logic [31:0] scale_axis(logic [31:0] src, logic [12:0] dim,
			logic [1:0] lvl, logic [11:0] pos, logic [12:0] sdim);
		longint span, div, q;
		span = (dim > MAX_DIM) ? MAX_DIM : dim;
		span = span >>> lvl;
		div = (sdim > MAX_DIM) ? MAX_DIM : sdim;
		if (div == 0)
			div = 1;
		q = (longint'($signed(src)) * span + longint'(pos) * 65536) / div;
		if (q > Q_MAX)
			q = Q_MAX;
		if (q < Q_MIN)
			q = Q_MIN;
		return q[31:0];
	endfunction

	function automatic sheet_coord_t predict_remap(logic [31:0] u, logic [31:0] v, logic last);
		sheet_coord_t r;
		logic [1:0] lvl;
		lvl = picmip_level();
		if (img_w < img_h) begin
			r.u = scale_axis(v, img_h, lvl, pos_x, sht_w);
			r.v = scale_axis(u, img_w, lvl, pos_y, sht_h);
		end else begin
			r.u = scale_axis(u, img_w, lvl, pos_x, sht_w);
			r.v = scale_axis(v, img_h, lvl, pos_y, sht_h);
		end
		r.last = last;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		if (errors < 100)
			$display("mismatch %s: got %h, expected %h", what, seen, wanted);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w      <= 13'd1;
			img_h      <= 13'd1;
			sht_w      <= 13'd1;
			sht_h      <= 13'd1;
			pos_x      <= '0;
			pos_y      <= '0;
			flags      <= '0;
			level_pair <= '0;
			pending_coords.delete();
			pending    <= 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_coords.push_back(predict_remap(s_tdata[31:0], s_tdata[63:32], s_tlast));
			if (m_tvalid && m_tready) begin
				got.u    = m_tdata[31:0];
				got.v    = m_tdata[63:32];
				got.last = m_tlast;
				if (pending_coords.size() == 0) begin
					report_mismatch("beat with nothing outstanding", got.u, '0);
				end else begin
					want = pending_coords.pop_front();
					if (got.u !== want.u)
						report_mismatch("sheet_u", got.u, want.u);
					if (got.v !== want.v)
						report_mismatch("sheet_v", got.v, want.v);
					if (got.last !== want.last)
						report_mismatch("last_out", {31'd0, got.last}, {31'd0, want.last});
				end
			end
			// register writes take effect for the beats after this edge
			if (cfg_we) begin
				case (cfg_addr)
					REG_IMAGE_WIDTH:  img_w      <= cfg_wdata[12:0];
					REG_IMAGE_HEIGHT: img_h      <= cfg_wdata[12:0];
					REG_SHEET_WIDTH:  sht_w      <= cfg_wdata[12:0];
					REG_SHEET_HEIGHT: sht_h      <= cfg_wdata[12:0];
					REG_SHEET_X:      pos_x      <= cfg_wdata[11:0];
					REG_SHEET_Y:      pos_y      <= cfg_wdata[11:0];
					REG_IMAGE_FLAGS:  flags      <= cfg_wdata[1:0];
					REG_PICMIP_PAIR:  level_pair <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			pending <= pending_coords.size();
		end
	end

endmodule

// ===== tb/sv/tb_atlas_texcoord_remap.sv =====
// tb_atlas_texcoord_remap: drives texture coordinates and register settings into the remap block
// with bursty input and stalling output; depends on atr_pkg, atlas_texcoord_remap, atr_remap_check

module tb_atlas_texcoord_remap;

	import atr_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 78;
	localparam int PRESSURE_PHASE = 6;
	localparam int STEADY_PHASE  = 3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [63:0]           m_tdata;
	logic                  m_tlast;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	int cycle_count = 0;
	int burst_left  = 0;
	bit steady_send  = 0;
	bit hold_request = 0;

	atlas_texcoord_remap dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	atr_remap_check remap_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output side: randomly chosen stall modes, plus one long hold
	initial begin
		int mode_left;
		int mode;
		int hold_left;
		logic [7:0] stall_pattern;
		mode_left = 0;
		mode = 0;
		hold_left = 0;
		stall_pattern = 8'hFF;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
					stall_pattern = 8'($urandom);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: begin
						m_tready <= stall_pattern[0];
						stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
					end
				endcase
			end
		end
	end

	task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic write_settings(input logic [15:0] iw, input logic [15:0] ih,
			input logic [15:0] sw, input logic [15:0] sh, input logic [15:0] px,
			input logic [15:0] py, input logic [15:0] fl, input logic [15:0] pp);
		put_reg(REG_IMAGE_WIDTH, iw);
		put_reg(REG_IMAGE_HEIGHT, ih);
		put_reg(REG_SHEET_WIDTH, sw);
		put_reg(REG_SHEET_HEIGHT, sh);
		put_reg(REG_SHEET_X, px);
		put_reg(REG_SHEET_Y, py);
		put_reg(REG_IMAGE_FLAGS, fl);
		put_reg(REG_PICMIP_PAIR, pp);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_all_results();
		do @(posedge clk); while (pending != 0);
	endtask

	// called in the step of the last accepted beat, so tvalid drops exactly once here
	task automatic end_phase();
		s_tvalid <= 1'b0;
		wait_all_results();
		burst_left = 0;
	endtask

	task automatic send_vertex(input logic [31:0] u, input logic [31:0] v, input logic last);
		int gap;
		if (burst_left == 0) begin
			if (steady_send)
				gap = 0;
			else if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(3, 20);
			else
				gap = $urandom_range(0, 2);
			burst_left = steady_send ? 64 : $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {v, u};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	function automatic logic [15:0] pick_dim();
		case ($urandom_range(0, 6))
			0: return 16'($urandom_range(1, 16));
			1: return 16'($urandom_range(1, 4096));
			2: return 16'd4096;
			3: return 16'($urandom_range(4097, 8191));
			4: return 16'd0;
			5: return 16'($urandom);
			default: return 16'($urandom_range(1, 512));
		endcase
	endfunction

	function automatic logic [7:0] pick_level_byte();
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'hFF;
			6: return 8'($urandom_range(4, 127));
			7: return 8'($urandom);
			default: return 8'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic logic [31:0] pick_coord();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return {{14{r[17]}}, r[17:0]};
			3: return 32'($urandom_range(0, 2)) - 32'd1;
			4, 5: return 32'($urandom_range(0, 32'h0001_0000));
			default: return r;
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register values straight after reset: identity mapping
		send_vertex(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_vertex(32'h0001_0000, 32'hFFFF_0000, 1'b0);
		end_phase();

		// full-size image in a sheet one texel wide: both saturation directions
		write_settings(16'd4096, 16'd4096, 16'd1, 16'd4096, 16'd4095, 16'd0, 16'd0, 16'd0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
		end_phase();

		// tall image swaps axes, zero sheet width, dims above the maximum, normal level 2
		write_settings(16'd3, 16'd8191, 16'd0, 16'd8191, 16'd100, 16'd200, 16'd1, 16'hFF02);
		send_vertex(32'h0001_0000, 32'h0002_0000, 1'b1);
		send_vertex(32'h1234_5678, 32'hFEDC_BA98, 1'b0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		end_phase();

		// zero image dims, negative alternate level, upper data bits set
		write_settings(16'hE000, 16'd0, 16'd5000, 16'd3, 16'hFFFF, 16'd4095, 16'hFFFF, 16'h8007);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_vertex(32'h0000_8000, 32'hFFFF_8000, 1'b0);
		end_phase();

		// alternate level above the range clamps to 3
		write_settings(16'd4096, 16'd17, 16'd4096, 16'd7, 16'd1, 16'd2, 16'd3, 16'h7F80);
		send_vertex(32'h0001_0000, 32'h0000_FFFF, 1'b0);
		send_vertex(32'hFFFE_0000, 32'h7FFF_FFFF, 1'b1);
		end_phase();

		// normal level above the range, square image
		write_settings(16'd16, 16'd16, 16'd64, 16'd64, 16'd48, 16'd16, 16'd1, 16'h0004);
		send_vertex(32'h0000_C000, 32'h0000_4000, 1'b0);
		send_vertex(32'hFFFF_C000, 32'h0001_0000, 1'b1);
		end_phase();

		// alternate selected but picmip not allowed: level stays 0
		write_settings(16'd300, 16'd200, 16'd1024, 16'd512, 16'd7, 16'd9, 16'd2, 16'h0303);
		send_vertex(32'h0000_8000, 32'h0000_8000, 1'b0);
		send_vertex(32'h0123_4567, 32'h89AB_CDEF, 1'b1);
		end_phase();

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase)
				0: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
						16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				1: write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				2: write_settings(16'd4096, 16'd1, 16'd4096, 16'd1,
						16'd4095, 16'd0, 16'd3, 16'h0303);
				default: write_settings(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
						16'($urandom), 16'($urandom), 16'($urandom),
						{pick_level_byte(), pick_level_byte()});
			endcase
			steady_send = (phase == PRESSURE_PHASE) || (phase == STEADY_PHASE);
			if (phase == PRESSURE_PHASE)
				hold_request = 1;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// sender waits for the pipeline to empty now and then
				if (n == PHASE_ITEMS / 2 && $urandom_range(0, 2) == 0)
					end_phase();
				send_vertex(pick_coord(), pick_coord(), $urandom_range(0, 7) == 0);
			end
			end_phase();
			steady_send = 0;
		end

		repeat (LAT + 4) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
